/* rtl/core/bzs_pkg.sv */
// Shared types, codes and fixed-point constants of the Bezier waypoint sampler.
// Used by the controller, the datapath, the divider and the top level.
package bzs_pkg;

	// fixed-point lengths, round(metres * 2^12)
	localparam int KQ_12 = 492;
	localparam int KQ_15 = 614;
	localparam int KQ_18 = 737;
	localparam int KQ_20 = 819;
	localparam int KQ_25 = 1024;
	localparam int KQ_35 = 1434;
	localparam int KQ_60 = 2458;
	localparam int KQ_80 = 3277;
	localparam int TOL_RESET = 410;
	localparam int CORDIC_GAIN = 9949;
	localparam int CORDIC_STEPS = 16;
	localparam int SQRT_STEPS = 25;
	localparam int DIV_BITS = 48;

	typedef struct packed {
		logic signed [23:0] pose_x;
		logic signed [23:0] pose_y;
		logic signed [15:0] pose_heading;
		logic               pose_ok;
		logic signed [23:0] goal_x;
		logic signed [23:0] goal_y;
		logic               goal_ok;
	} req_t;

	typedef struct packed {
		logic signed [23:0] waypoint_x;
		logic signed [23:0] waypoint_y;
		logic               final_point;
	} wpt_t;

	typedef enum logic [5:0] {
		OP_NOP, OP_LOAD, OP_DIFF, OP_MXX, OP_MYY, OP_MDZ, OP_CMP, OP_ITER,
		OP_MCDX, OP_MSDY, OP_MHS, OP_MHE, OP_MCH, OP_MSH, OP_MDXHE, OP_MDYHE,
		OP_DIVP2, OP_P2, OP_MMS, OP_NINIT, OP_NCNT, OP_MN2, OP_MN3, OP_N3,
		OP_W1, OP_W2, OP_M0, OP_M1, OP_M2, OP_M3, OP_SUM, OP_DIVQ, OP_Q,
		OP_MEX, OP_MEY, OP_EMIT, OP_NEXT, OP_EGOAL
	} op_t;

	typedef enum logic [5:0] {
		ST_IDLE, ST_CHKOK, ST_DIFF, ST_MXX, ST_MYY, ST_MDZ, ST_CMP, ST_ITER,
		ST_MCDX, ST_MSDY, ST_MHS, ST_MHE, ST_MCH, ST_MSH, ST_MDXHE, ST_DIVX,
		ST_WAITX, ST_P2X, ST_MDYHE, ST_DIVY, ST_WAITY, ST_P2Y, ST_MMS, ST_NINIT,
		ST_NCNT, ST_MN2, ST_MN3, ST_N3, ST_W1, ST_W2, ST_M0, ST_M1, ST_M2,
		ST_M3, ST_SUM, ST_DIVQ, ST_WAITQ, ST_Q, ST_MEX, ST_MEY, ST_E2,
		ST_EMIT, ST_NEXT, ST_EGOAL
	} state_t;

	typedef struct packed {
		op_t        op;
		logic [4:0] idx;
		logic       axis;
	} cmd_t;

	typedef struct packed {
		logic ok;
		logic near;
		logic div_busy;
		logic n_done;
		logic skip;
		logic fin;
		logic out_free;
	} sts_t;

	// arctangent of 2^-i, pi = 2^20
	function automatic logic [18:0] atan_lut(input logic [3:0] i);
		case (i)
			4'd0:    atan_lut = 19'd262144;
			4'd1:    atan_lut = 19'd154753;
			4'd2:    atan_lut = 19'd81767;
			4'd3:    atan_lut = 19'd41506;
			4'd4:    atan_lut = 19'd20834;
			4'd5:    atan_lut = 19'd10427;
			4'd6:    atan_lut = 19'd5215;
			4'd7:    atan_lut = 19'd2608;
			4'd8:    atan_lut = 19'd1304;
			4'd9:    atan_lut = 19'd652;
			4'd10:   atan_lut = 19'd326;
			4'd11:   atan_lut = 19'd163;
			4'd12:   atan_lut = 19'd81;
			4'd13:   atan_lut = 19'd41;
			4'd14:   atan_lut = 19'd20;
			4'd15:   atan_lut = 19'd10;
			default: atan_lut = 19'd0;
		endcase
	endfunction

endpackage

/* rtl/core/bzs_div.sv */
// Restoring divider, one quotient bit per cycle, rounding half away from zero.
// Depends on bzs_pkg.
module bzs_div import bzs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [47:0] num,
	input  logic        [25:0] den,
	output logic               busy,
	output logic signed [26:0] quo
);
	logic [47:0] mag_q;
	logic [25:0] rem_q;
	logic [25:0] den_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [47:0] abs_n;
	logic [26:0] cand;

	assign abs_n = num[47] ? 48'(-num) : 48'(num);
	assign cand  = {rem_q, mag_q[47]};

	// shift in one dividend bit a cycle, subtract when it fits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'(DIV_BITS - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) busy_q <= 1'b0;
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= abs_n + 48'(den >> 1);
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[47];
		end else if (busy_q) begin
			if (cand >= {1'b0, den_q}) begin
				rem_q <= 26'(cand - {1'b0, den_q});
				mag_q <= {mag_q[46:0], 1'b1};
			end else begin
				rem_q <= cand[25:0];
				mag_q <= {mag_q[46:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quo  = neg_q ? -$signed(mag_q[26:0]) : $signed(mag_q[26:0]);
endmodule

/* rtl/core/bzs_dp.sv */
// Datapath: shared multiplier, square root and CORDIC steppers, curve sums, output beat.
// Depends on bzs_pkg and bzs_div.
module bzs_dp import bzs_pkg::*; #(
	parameter int MAX_SAMPLES = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  req_t        req,
	input  logic        cfg_valid,
	input  logic [14:0] cfg_data,
	output logic        wpt_valid,
	input  logic        wpt_stall,
	output wpt_t        wpt
);
	localparam int NW  = $clog2(MAX_SAMPLES + 1);
	localparam int N3W = $clog2(MAX_SAMPLES * MAX_SAMPLES * MAX_SAMPLES + 1);

	req_t               in_q;
	logic [14:0]        tol_q;
	logic signed [24:0] dx_q, dy_q;
	logic signed [54:0] prod_q;
	logic signed [51:0] acc_q;
	logic [49:0]        d2_q, sv_q, sr_q, sb_q;
	logic signed [19:0] cx_q, cy_q;
	logic signed [21:0] cz_q;
	logic               behind_q;
	logic [11:0]        hs_q, he_q;
	logic signed [25:0] p1x_q, p1y_q, p2x_q, p2y_q;
	logic signed [25:0] qx_q, qy_q, lx_q, ly_q;
	logic [31:0]        ms2_q;
	logic [NW-1:0]      n_q, i_q;
	logic [N3W-1:0]     n3_q, w0_q, w1_q, w2_q, w3_q;
	logic [2*NW-1:0]    uu_q, ii_q;
	logic               wpt_valid_q;
	wpt_t               wpt_q;

	logic signed [27:0] mul_a;
	logic signed [26:0] mul_b;
	logic signed [54:0] mul_p;
	logic [14:0]        dz, ms;
	logic [25:0]        dlen;
	logic [NW-1:0]      u;
	logic signed [26:0] ex, ey;
	logic signed [25:0] pt;
	logic [N3W-1:0]     wt;
	logic signed [55:0] psum;
	logic [42:0]        hs_raw, he_raw;
	logic [11:0]        hs_c, he_c;
	logic signed [21:0] z0, zf;
	logic signed [19:0] xs, ys;
	logic [50:0]        trial;
	logic [31:0]        nthr;
	logic               div_start;
	logic signed [47:0] div_num;
	logic [25:0]        div_den;
	logic               div_busy;
	logic signed [26:0] div_q;
	logic               out_free;

	function automatic logic signed [40:0] rnd14(input logic signed [54:0] a);
		if (a >= 0) rnd14 = 41'((a + 55'sd8192) >>> 14);
		else rnd14 = -41'((-a + 55'sd8192) >>> 14);
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
		if (v > 26'sd8388607) sat24 = {1'b0, {23{1'b1}}};
		else if (v < -26'sd8388608) sat24 = {1'b1, 23'b0};
		else sat24 = v[23:0];
	endfunction

	// derived lengths
	assign dz   = (tol_q < 15'(KQ_12)) ? 15'(KQ_12) : tol_q;
	assign ms   = (dz > 15'(KQ_18)) ? dz : 15'(KQ_18);
	assign dlen = sr_q[25:0];
	assign u    = n_q - i_q;
	assign ex   = 27'(qx_q) - 27'(lx_q);
	assign ey   = 27'(qy_q) - 27'(ly_q);
	assign psum = 56'(acc_q) + 56'(prod_q);
	assign nthr = 32'(n_q) * 32'(KQ_20);
	assign out_free = !wpt_valid_q || !wpt_stall;

	// handle lengths, rounded and clamped
	assign hs_raw = 43'((prod_q + 55'sd2048) >>> 12);
	assign he_raw = hs_raw;
	assign hs_c = (hs_raw < 43'(KQ_20)) ? 12'(KQ_20) :
		((hs_raw > 43'(KQ_80)) ? 12'(KQ_80) : hs_raw[11:0]);
	assign he_c = (he_raw < 43'(KQ_15)) ? 12'(KQ_15) :
		((he_raw > 43'(KQ_60)) ? 12'(KQ_60) : he_raw[11:0]);

	// heading folded into the right half plane
	assign z0 = 22'($signed({in_q.pose_heading, 5'b0}));
	always_comb begin
		if (z0 > 22'sd524288) zf = z0 - 22'sd1048576;
		else if (z0 < -22'sd524288) zf = z0 + 22'sd1048576;
		else zf = z0;
	end
	assign xs = cx_q >>> cmd.idx[3:0];
	assign ys = cy_q >>> cmd.idx[3:0];
	assign trial = 51'(sr_q) + 51'(sb_q);

	// control point and weight for the current curve term
	always_comb begin
		pt = '0;
		wt = '0;
		case (cmd.op)
			OP_M0: begin
				pt = cmd.axis ? 26'(in_q.pose_y) : 26'(in_q.pose_x);
				wt = w0_q;
			end
			OP_M1: begin
				pt = cmd.axis ? p1y_q : p1x_q;
				wt = w1_q;
			end
			OP_M2: begin
				pt = cmd.axis ? p2y_q : p2x_q;
				wt = w2_q;
			end
			OP_M3: begin
				pt = cmd.axis ? 26'(in_q.goal_y) : 26'(in_q.goal_x);
				wt = w3_q;
			end
			default: begin
				pt = '0;
				wt = '0;
			end
		endcase
	end

	// select multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_MXX:   begin mul_a = 28'(dx_q); mul_b = 27'(dx_q); end
			OP_MYY:   begin mul_a = 28'(dy_q); mul_b = 27'(dy_q); end
			OP_MDZ:   begin mul_a = 28'(dz); mul_b = 27'(dz); end
			OP_MCDX:  begin mul_a = 28'(cx_q); mul_b = 27'(dx_q); end
			OP_MSDY:  begin mul_a = 28'(cy_q); mul_b = 27'(dy_q); end
			OP_MHS:   begin mul_a = 28'(dlen); mul_b = 27'(KQ_35); end
			OP_MHE:   begin mul_a = 28'(dlen); mul_b = 27'(KQ_25); end
			OP_MCH:   begin mul_a = 28'(cx_q); mul_b = 27'(hs_q); end
			OP_MSH:   begin mul_a = 28'(cy_q); mul_b = 27'(hs_q); end
			OP_MDXHE: begin mul_a = 28'(dx_q); mul_b = 27'(he_q); end
			OP_MDYHE: begin mul_a = 28'(dy_q); mul_b = 27'(he_q); end
			OP_MMS:   begin mul_a = 28'(ms); mul_b = 27'(ms); end
			OP_MN2:   begin mul_a = 28'(n_q); mul_b = 27'(n_q); end
			OP_MN3:   begin mul_a = 28'(prod_q[2*NW-1:0]); mul_b = 27'(n_q); end
			OP_M0, OP_M1, OP_M2, OP_M3: begin
				mul_a = 28'(pt);
				mul_b = 27'(wt);
			end
			OP_MEX:   begin mul_a = 28'(ex); mul_b = ex; end
			OP_MEY:   begin mul_a = 28'(ey); mul_b = ey; end
			default:  begin mul_a = '0; mul_b = '0; end
		endcase
	end
	assign mul_p = 55'(mul_a) * 55'(mul_b);

	// divider operands
	assign div_start = (cmd.op == OP_DIVP2) || (cmd.op == OP_DIVQ);
	assign div_num   = (cmd.op == OP_DIVQ) ? $signed(acc_q[47:0]) : $signed(prod_q[47:0]);
	assign div_den   = (cmd.op == OP_DIVQ) ? 26'(n3_q) : dlen;

	bzs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (div_q)
	);

	// hold the tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tol_q <= 15'(TOL_RESET);
		else if (cfg_valid) tol_q <= cfg_data;
	end

	// advance the output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) wpt_valid_q <= 1'b0;
		else if (cmd.op == OP_EMIT || cmd.op == OP_EGOAL) wpt_valid_q <= 1'b1;
		else if (!wpt_stall) wpt_valid_q <= 1'b0;
	end

	// working registers, stepped by the controller
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		case (cmd.op)
			OP_LOAD: in_q <= req;
			OP_DIFF: begin
				dx_q <= 25'(in_q.goal_x) - 25'(in_q.pose_x);
				dy_q <= 25'(in_q.goal_y) - 25'(in_q.pose_y);
			end
			OP_MYY:  acc_q <= 52'(prod_q);
			OP_MDZ:  d2_q <= 50'(psum);
			OP_CMP: begin
				sv_q <= d2_q;
				sr_q <= '0;
				sb_q <= 50'd1 << 48;
				cx_q <= (zf == z0) ? 20'sd9949 : -20'sd9949;
				cy_q <= '0;
				cz_q <= zf;
			end
			OP_ITER: begin
				if ({1'b0, sv_q} >= trial) begin
					sv_q <= sv_q - trial[49:0];
					sr_q <= (sr_q >> 1) + sb_q;
				end else begin
					sr_q <= sr_q >> 1;
				end
				sb_q <= sb_q >> 2;
				if (cmd.idx < 5'(CORDIC_STEPS)) begin
					if (cz_q >= 0) begin
						cx_q <= cx_q - ys;
						cy_q <= cy_q + xs;
						cz_q <= cz_q - 22'(atan_lut(cmd.idx[3:0]));
					end else begin
						cx_q <= cx_q + ys;
						cy_q <= cy_q - xs;
						cz_q <= cz_q + 22'(atan_lut(cmd.idx[3:0]));
					end
				end
			end
			OP_MSDY: acc_q <= 52'(prod_q);
			OP_MHS:  behind_q <= (psum < 0);
			OP_MHE:  hs_q <= behind_q ? 12'(KQ_12) : hs_c;
			OP_MCH:  he_q <= he_c;
			OP_MSH:  p1x_q <= 26'(in_q.pose_x) + 26'(rnd14(prod_q));
			OP_MDXHE: p1y_q <= 26'(in_q.pose_y) + 26'(rnd14(prod_q));
			OP_P2: begin
				if (cmd.axis) p2y_q <= 26'(in_q.goal_y) - 26'(div_q);
				else p2x_q <= 26'(in_q.goal_x) - 26'(div_q);
			end
			OP_NINIT: begin
				ms2_q <= prod_q[31:0];
				n_q   <= NW'(4);
			end
			OP_NCNT: if (!sts.n_done) n_q <= n_q + NW'(1);
			OP_N3: begin
				n3_q <= prod_q[N3W-1:0];
				i_q  <= NW'(1);
				lx_q <= 26'(in_q.pose_x);
				ly_q <= 26'(in_q.pose_y);
			end
			OP_W1: begin
				uu_q <= (2*NW)'(u * u);
				ii_q <= (2*NW)'(i_q * i_q);
			end
			OP_W2: begin
				w0_q <= N3W'(32'(uu_q) * 32'(u));
				w1_q <= N3W'(32'd3 * 32'(uu_q) * 32'(i_q));
				w2_q <= N3W'(32'd3 * 32'(ii_q) * 32'(u));
				w3_q <= N3W'(32'(ii_q) * 32'(i_q));
			end
			OP_M1:   acc_q <= 52'(prod_q);
			OP_M2, OP_M3, OP_SUM: acc_q <= 52'(psum);
			OP_Q: begin
				if (cmd.axis) qy_q <= div_q[25:0];
				else qx_q <= div_q[25:0];
			end
			OP_MEY:  acc_q <= 52'(prod_q);
			OP_EMIT: begin
				wpt_q.waypoint_x  <= sat24(qx_q);
				wpt_q.waypoint_y  <= sat24(qy_q);
				wpt_q.final_point <= (i_q == n_q);
				lx_q <= qx_q;
				ly_q <= qy_q;
			end
			OP_NEXT: i_q <= i_q + NW'(1);
			OP_EGOAL: begin
				wpt_q.waypoint_x  <= in_q.goal_x;
				wpt_q.waypoint_y  <= in_q.goal_y;
				wpt_q.final_point <= 1'b1;
			end
			default: ;
		endcase
	end

	// status back to the controller
	always_comb begin
		sts.ok       = in_q.pose_ok && in_q.goal_ok;
		sts.near     = (d2_q <= 50'({prod_q[29:0], 2'b00}));
		sts.div_busy = div_busy;
		sts.n_done   = !((32'(n_q) < 32'(MAX_SAMPLES)) && (32'(dlen) > nthr));
		sts.fin      = (i_q == n_q);
		sts.skip     = !sts.fin && (psum < $signed({24'b0, ms2_q}));
		sts.out_free = out_free;
	end

	assign wpt_valid = wpt_valid_q;
	assign wpt       = wpt_q;
endmodule

/* rtl/core/bzs_ctrl.sv */
// Controller state machine: sequences the datapath, one command per cycle
// while no divider or output wait holds it. Depends on bzs_pkg.
module bzs_ctrl import bzs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  sts_t sts,
	output cmd_t cmd
);
	state_t     st_q, st_nxt;
	logic [4:0] cnt_q, cnt_nxt;
	logic       axis_q, axis_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			cnt_q  <= '0;
			axis_q <= 1'b0;
		end else begin
			st_q   <= st_nxt;
			cnt_q  <= cnt_nxt;
			axis_q <= axis_nxt;
		end
	end

	// next state and command
	always_comb begin
		st_nxt   = st_q;
		cnt_nxt  = cnt_q;
		axis_nxt = axis_q;
		cmd.op   = OP_NOP;
		cmd.idx  = cnt_q;
		cmd.axis = axis_q;
		case (st_q)
			ST_IDLE: if (req_valid) begin
				cmd.op = OP_LOAD;
				st_nxt = ST_CHKOK;
			end
			ST_CHKOK: st_nxt = sts.ok ? ST_DIFF : ST_IDLE;
			ST_DIFF:  begin cmd.op = OP_DIFF; st_nxt = ST_MXX; end
			ST_MXX:   begin cmd.op = OP_MXX; st_nxt = ST_MYY; end
			ST_MYY:   begin cmd.op = OP_MYY; st_nxt = ST_MDZ; end
			ST_MDZ:   begin cmd.op = OP_MDZ; st_nxt = ST_CMP; end
			ST_CMP: begin
				cmd.op  = OP_CMP;
				cnt_nxt = '0;
				st_nxt  = sts.near ? ST_EGOAL : ST_ITER;
			end
			ST_ITER: begin
				cmd.op = OP_ITER;
				if (cnt_q == 5'(SQRT_STEPS - 1)) st_nxt = ST_MCDX;
				else cnt_nxt = cnt_q + 5'd1;
			end
			ST_MCDX:  begin cmd.op = OP_MCDX; st_nxt = ST_MSDY; end
			ST_MSDY:  begin cmd.op = OP_MSDY; st_nxt = ST_MHS; end
			ST_MHS:   begin cmd.op = OP_MHS; st_nxt = ST_MHE; end
			ST_MHE:   begin cmd.op = OP_MHE; st_nxt = ST_MCH; end
			ST_MCH:   begin cmd.op = OP_MCH; st_nxt = ST_MSH; end
			ST_MSH:   begin cmd.op = OP_MSH; st_nxt = ST_MDXHE; end
			ST_MDXHE: begin cmd.op = OP_MDXHE; st_nxt = ST_DIVX; end
			ST_DIVX:  begin cmd.op = OP_DIVP2; cmd.axis = 1'b0; st_nxt = ST_WAITX; end
			ST_WAITX: if (!sts.div_busy) st_nxt = ST_P2X;
			ST_P2X:   begin cmd.op = OP_P2; cmd.axis = 1'b0; st_nxt = ST_MDYHE; end
			ST_MDYHE: begin cmd.op = OP_MDYHE; st_nxt = ST_DIVY; end
			ST_DIVY:  begin cmd.op = OP_DIVP2; cmd.axis = 1'b1; st_nxt = ST_WAITY; end
			ST_WAITY: if (!sts.div_busy) st_nxt = ST_P2Y;
			ST_P2Y:   begin cmd.op = OP_P2; cmd.axis = 1'b1; st_nxt = ST_MMS; end
			ST_MMS:   begin cmd.op = OP_MMS; st_nxt = ST_NINIT; end
			ST_NINIT: begin cmd.op = OP_NINIT; st_nxt = ST_NCNT; end
			ST_NCNT: begin
				cmd.op = OP_NCNT;
				if (sts.n_done) st_nxt = ST_MN2;
			end
			ST_MN2:   begin cmd.op = OP_MN2; st_nxt = ST_MN3; end
			ST_MN3:   begin cmd.op = OP_MN3; st_nxt = ST_N3; end
			ST_N3:    begin cmd.op = OP_N3; st_nxt = ST_W1; end
			ST_W1: begin
				cmd.op   = OP_W1;
				axis_nxt = 1'b0;
				st_nxt   = ST_W2;
			end
			ST_W2:    begin cmd.op = OP_W2; st_nxt = ST_M0; end
			ST_M0:    begin cmd.op = OP_M0; st_nxt = ST_M1; end
			ST_M1:    begin cmd.op = OP_M1; st_nxt = ST_M2; end
			ST_M2:    begin cmd.op = OP_M2; st_nxt = ST_M3; end
			ST_M3:    begin cmd.op = OP_M3; st_nxt = ST_SUM; end
			ST_SUM:   begin cmd.op = OP_SUM; st_nxt = ST_DIVQ; end
			ST_DIVQ:  begin cmd.op = OP_DIVQ; st_nxt = ST_WAITQ; end
			ST_WAITQ: if (!sts.div_busy) st_nxt = ST_Q;
			ST_Q: begin
				cmd.op = OP_Q;
				if (!axis_q) begin
					axis_nxt = 1'b1;
					st_nxt   = ST_M0;
				end else begin
					st_nxt = ST_MEX;
				end
			end
			ST_MEX:   begin cmd.op = OP_MEX; st_nxt = ST_MEY; end
			ST_MEY:   begin cmd.op = OP_MEY; st_nxt = ST_E2; end
			ST_E2:    st_nxt = sts.skip ? ST_NEXT : ST_EMIT;
			ST_EMIT: if (sts.out_free) begin
				cmd.op = OP_EMIT;
				st_nxt = sts.fin ? ST_IDLE : ST_NEXT;
			end
			ST_NEXT:  begin cmd.op = OP_NEXT; st_nxt = ST_W1; end
			ST_EGOAL: if (sts.out_free) begin
				cmd.op = OP_EGOAL;
				st_nxt = ST_IDLE;
			end
			default:  st_nxt = ST_IDLE;
		endcase
	end

	assign req_stall = (st_q != ST_IDLE);
endmodule

/* rtl/core/bezier_path_waypoint_sampler.v.sv */
// Cubic Bezier waypoint sampler, top level; one item in flight, input stalled until it ends.
// Setup runs a 25-step square root with the CORDIC inside it, then the two end-handle divisions,
// sizes the curve and takes two 48-bit divisions per sample; output stalls lengthen the run, and
// throughput is one item per run.
// Goal inside the deadzone: a single goal beat; invalid input: back to idle with no beat.
// Reset: asynchronous, active low; tolerance returns to 410, controller to idle.
module bezier_path_waypoint_sampler import bzs_pkg::*; #(
	parameter int MAX_SAMPLES = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        wpt_valid,
	input  logic        wpt_stall,
	output wpt_t        wpt,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [14:0] cfg_data
);
	cmd_t cmd;
	sts_t sts;

	bzs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	bzs_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.wpt_valid (wpt_valid),
		.wpt_stall (wpt_stall),
		.wpt       (wpt)
	);

	// take a tolerance write on any cycle
	assign cfg_ready = 1'b1;
endmodule
